// ===== rtl/ptc_pkg.sv =====
// Package for the pressure and temperature compensation core.
// Holds register codes, compensation constants and the divider result type.
// No dependencies.
package ptc_pkg;

  localparam logic [63:0] TempOffset = 64'd128000;
  localparam logic [63:0] PressBase = 64'd1048576;
  localparam logic [63:0] PressScale = 64'd3125;
  localparam logic [31:0] RoundHalf = 32'd128;

  localparam int unsigned DivStages = 64;
  localparam int unsigned DivLat = DivStages + 2;

  typedef enum logic [1:0] {
    REG_TEMP      = 2'd0,
    REG_PRESS_LO  = 2'd1,
    REG_PRESS_MID = 2'd2,
    REG_PRESS_HI  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] quo;
    logic        zero;
  } div_res_t;

endpackage

// ===== rtl/ptc_delay.sv =====
// Enabled shift line that delays a word through Depth registers.
// No dependencies.
module ptc_delay #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < Depth; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[Depth-1];

endmodule

// ===== rtl/ptc_mul64.sv =====
// Two-stage multiplier that returns the low 64 bits of a 64 by 64 product.
// Built from 32 by 32 partial products; no dependencies.
module ptc_mul64 (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_q;
  logic [31:0] cross_q;
  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q    <= a_i[31:0] * b_i[31:0];
      cross_q <= a_i[31:0] * b_i[63:32] + a_i[63:32] * b_i[31:0];
      p_q     <= ll_q + {cross_q, 32'd0};
    end
  end

  assign p_o = p_q;

endmodule

// ===== rtl/ptc_div.sv =====
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// Depends on ptc_pkg for the stage count and the result type.
module ptc_div import ptc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output div_res_t    res_o
);

  logic [63:0] rem_q  [DivStages+1];
  logic [63:0] num_q  [DivStages+1];
  logic [63:0] den_q  [DivStages+1];
  logic        neg_q  [DivStages+1];
  logic        zero_q [DivStages+1];
  div_res_t    res_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q[0]  <= num_i[63] ^ den_i[63];
      zero_q[0] <= (den_i == 64'd0);
      num_q[0]  <= num_i[63] ? (64'd0 - num_i) : num_i;
      den_q[0]  <= den_i[63] ? (64'd0 - den_i) : den_i;
      rem_q[0]  <= 64'd0;
    end
  end

  for (genvar k = 0; k < DivStages; k++) begin : g_step
    logic [63:0] shifted;
    logic [64:0] diff;

    assign shifted = {rem_q[k][62:0], num_q[k][63]};
    assign diff    = {1'b0, shifted} - {1'b0, den_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= diff[64] ? shifted : diff[63:0];
        num_q[k+1]  <= {num_q[k][62:0], ~diff[64]};
        den_q[k+1]  <= den_q[k];
        neg_q[k+1]  <= neg_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.quo  <= neg_q[DivStages] ? (64'd0 - num_q[DivStages]) : num_q[DivStages];
      res_q.zero <= zero_q[DivStages];
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/pressure_temperature_compensation_core.sv =====
// Top level of the pressure and temperature compensation core.
// Depends on ptc_pkg, ptc_delay, ptc_mul64 and ptc_div.

// The core takes one raw pressure and temperature word per cycle and returns
// the fine temperature, the temperature in hundredths of a degree and the
// pressure in pascals; the 66-stage divider makes up most of the pipeline.
// When the output is stalled the whole pipeline holds and in_ready_o drops.
module pressure_temperature_compensation_core import ptc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [19:0] pressure_raw_i,
  input  logic [19:0] temperature_raw_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] fine_temperature_o,
  output logic signed [31:0] temperature_centi_o,
  output logic [31:0] pressure_pascal_o,
  output logic        result_valid_o
);

  localparam int unsigned Lat = 19 + DivLat;

  logic [47:0] coef_q [4];
  logic        en;
  logic [Lat-1:0] v_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        coef_q[i] <= 48'd0;
      end
    end else if (psel && penable && pwrite) begin
      coef_q[paddr[4:3]] <= pwdata[47:0];
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:3]))
      REG_TEMP:      prdata = {16'd0, coef_q[REG_TEMP]};
      REG_PRESS_LO:  prdata = {16'd0, coef_q[REG_PRESS_LO]};
      REG_PRESS_MID: prdata = {16'd0, coef_q[REG_PRESS_MID]};
      REG_PRESS_HI:  prdata = {16'd0, coef_q[REG_PRESS_HI]};
      default:       prdata = 64'd0;
    endcase
  end

  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = {16'd0, coef_q[REG_TEMP][15:0]};
  assign t2 = {{16{coef_q[REG_TEMP][31]}}, coef_q[REG_TEMP][31:16]};
  assign t3 = {{16{coef_q[REG_TEMP][47]}}, coef_q[REG_TEMP][47:32]};
  assign p1 = {48'd0, coef_q[REG_PRESS_LO][15:0]};
  assign p2 = {{48{coef_q[REG_PRESS_LO][31]}}, coef_q[REG_PRESS_LO][31:16]};
  assign p3 = {{48{coef_q[REG_PRESS_LO][47]}}, coef_q[REG_PRESS_LO][47:32]};
  assign p4 = {{48{coef_q[REG_PRESS_MID][15]}}, coef_q[REG_PRESS_MID][15:0]};
  assign p5 = {{48{coef_q[REG_PRESS_MID][31]}}, coef_q[REG_PRESS_MID][31:16]};
  assign p6 = {{48{coef_q[REG_PRESS_MID][47]}}, coef_q[REG_PRESS_MID][47:32]};
  assign p7 = {{48{coef_q[REG_PRESS_HI][15]}}, coef_q[REG_PRESS_HI][15:0]};
  assign p8 = {{48{coef_q[REG_PRESS_HI][31]}}, coef_q[REG_PRESS_HI][31:16]};
  assign p9 = {{48{coef_q[REG_PRESS_HI][47]}}, coef_q[REG_PRESS_HI][47:32]};

  assign en          = out_ready_i || !out_valid_o;
  assign in_ready_o  = en;
  assign out_valid_o = v_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[Lat-2:0], in_valid_i};
    end
  end

  logic [31:0] a_q, d_q, m1_q, dd_q, v1_q, m2_q, fine4_q, fine5_q, centi5_q;
  logic [19:0] adcp_q;
  logic [63:0] w1_q;
  logic [31:0] dd_sh, fine_x5;

  assign dd_sh   = 32'($signed(dd_q) >>> 12);
  assign fine_x5 = {fine4_q[29:0], 2'b00} + fine4_q + RoundHalf;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q      <= {15'd0, temperature_raw_i[19:3]} - {15'd0, t1[15:0], 1'b0};
      d_q      <= {16'd0, temperature_raw_i[19:4]} - t1;
      adcp_q   <= pressure_raw_i;
      m1_q     <= a_q * t2;
      dd_q     <= d_q * d_q;
      v1_q     <= 32'($signed(m1_q) >>> 11);
      m2_q     <= dd_sh * t3;
      fine4_q  <= v1_q + 32'($signed(m2_q) >>> 14);
      fine5_q  <= fine4_q;
      centi5_q <= 32'($signed(fine_x5) >>> 8);
      w1_q     <= {{32{fine4_q[31]}}, fine4_q} - TempOffset;
    end
  end

  logic [63:0] sq7, w1p5_7, w1p2_7, w2a9, sqp3_9, w1p5_9, w1p2_9;

  ptc_mul64 u_mul_sq (.clk_i, .en_i(en), .a_i(w1_q), .b_i(w1_q), .p_o(sq7));
  ptc_mul64 u_mul_p5 (.clk_i, .en_i(en), .a_i(w1_q), .b_i(p5), .p_o(w1p5_7));
  ptc_mul64 u_mul_p2 (.clk_i, .en_i(en), .a_i(w1_q), .b_i(p2), .p_o(w1p2_7));
  ptc_mul64 u_mul_p6 (.clk_i, .en_i(en), .a_i(sq7), .b_i(p6), .p_o(w2a9));
  ptc_mul64 u_mul_p3 (.clk_i, .en_i(en), .a_i(sq7), .b_i(p3), .p_o(sqp3_9));

  ptc_delay #(.Width(64), .Depth(2)) u_dly_p5 (
    .clk_i, .en_i(en), .d_i(w1p5_7), .q_o(w1p5_9)
  );
  ptc_delay #(.Width(64), .Depth(2)) u_dly_p2 (
    .clk_i, .en_i(en), .d_i(w1p2_7), .q_o(w1p2_9)
  );

  logic [63:0] w2_q, x_q, num0_q, y12, den12, num13, den13_q, pn;
  logic [19:0] adcp10;

  ptc_delay #(.Width(20), .Depth(9)) u_dly_adcp (
    .clk_i, .en_i(en), .d_i(adcp_q), .q_o(adcp10)
  );

  assign pn    = PressBase - {44'd0, adcp10};
  assign den12 = 64'($signed(y12) >>> 33);

  always_ff @(posedge clk_i) begin
    if (en) begin
      w2_q    <= w2a9 + {w1p5_9[46:0], 17'd0} + {p4[28:0], 35'd0};
      x_q     <= 64'($signed(sqp3_9) >>> 8) + {w1p2_9[51:0], 12'd0};
      num0_q  <= {pn[32:0], 31'd0} - w2_q;
      den13_q <= den12;
    end
  end

  ptc_mul64 u_mul_p1 (
    .clk_i, .en_i(en), .a_i(x_q + {16'd1, 47'd0}), .b_i(p1), .p_o(y12)
  );
  ptc_mul64 u_mul_sc (.clk_i, .en_i(en), .a_i(num0_q), .b_i(PressScale), .p_o(num13));

  div_res_t div_res;

  ptc_div u_div (.clk_i, .en_i(en), .num_i(num13), .den_i(den13_q), .res_o(div_res));

  logic [63:0] qq, qsq81, p8p81, t83, p8p83, p83, sum_q, s8;
  logic        zero84;

  assign qq = 64'($signed(div_res.quo) >>> 13);

  ptc_mul64 u_mul_qq (.clk_i, .en_i(en), .a_i(qq), .b_i(qq), .p_o(qsq81));
  ptc_mul64 u_mul_p8 (.clk_i, .en_i(en), .a_i(div_res.quo), .b_i(p8), .p_o(p8p81));
  ptc_mul64 u_mul_p9 (.clk_i, .en_i(en), .a_i(qsq81), .b_i(p9), .p_o(t83));

  ptc_delay #(.Width(64), .Depth(2)) u_dly_p8 (
    .clk_i, .en_i(en), .d_i(p8p81), .q_o(p8p83)
  );
  ptc_delay #(.Width(64), .Depth(4)) u_dly_p (
    .clk_i, .en_i(en), .d_i(div_res.quo), .q_o(p83)
  );
  ptc_delay #(.Width(1), .Depth(5)) u_dly_zero (
    .clk_i, .en_i(en), .d_i(div_res.zero), .q_o(zero84)
  );

  logic [31:0] fine85, centi85, press_q;
  logic        res_valid_q;

  ptc_delay #(.Width(32), .Depth(Lat - 5)) u_dly_fine (
    .clk_i, .en_i(en), .d_i(fine5_q), .q_o(fine85)
  );
  ptc_delay #(.Width(32), .Depth(Lat - 5)) u_dly_centi (
    .clk_i, .en_i(en), .d_i(centi5_q), .q_o(centi85)
  );

  assign s8 = 64'($signed(sum_q) >>> 8) + {p7[59:0], 4'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q       <= p83 + 64'($signed(t83) >>> 25) + 64'($signed(p8p83) >>> 19);
      press_q     <= zero84 ? 32'd0 : s8[39:8];
      res_valid_q <= !zero84;
    end
  end

  assign fine_temperature_o  = fine85;
  assign temperature_centi_o = centi85;
  assign pressure_pascal_o   = press_q;
  assign result_valid_o      = res_valid_q;

`ifndef NO_ASSERTIONS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_valid_o |-> pressure_pascal_o == 32'd0)
    else $error("invalid result carries nonzero pressure");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("valid pipeline moved during a stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted word did not enter the pipeline");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Testbench for pressure_temperature_compensation_core: random and directed raw readings
// under several calibration settings, checked against a scoreboard class with its own predictor.
// Depends on ptc_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;
  import ptc_pkg::*;

  typedef struct packed {
    bit [31:0] fine;
    bit [31:0] centi;
    bit [31:0] pascal;
    bit        ok;
  } comp_word_t;

  class comp_scoreboard;
    bit [47:0]  coef_reg[4];
    comp_word_t pending_q[$];
    int         n_err;
    int         n_seen;
    int         n_invalid;

    function bit [31:0] sx16_32(bit [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    function bit [63:0] sx16_64(bit [15:0] v);
      return {{48{v[15]}}, v};
    endfunction

    function bit [63:0] quot_trunc(bit [63:0] n, bit [63:0] d);
      bit [63:0] mn, md, q;
      mn = n[63] ? -n : n;
      md = d[63] ? -d : d;
      q = mn / md;
      return (n[63] != d[63]) ? -q : q;
    endfunction

    function comp_word_t compensate(bit [19:0] adc_p, bit [19:0] adc_t);
      comp_word_t r;
      bit [31:0] t1, t2, t3, a, d, v1, v2, fine;
      bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, p, q;
      t1 = {16'd0, coef_reg[REG_TEMP][15:0]};
      t2 = sx16_32(coef_reg[REG_TEMP][31:16]);
      t3 = sx16_32(coef_reg[REG_TEMP][47:32]);
      p1 = {48'd0, coef_reg[REG_PRESS_LO][15:0]};
      p2 = sx16_64(coef_reg[REG_PRESS_LO][31:16]);
      p3 = sx16_64(coef_reg[REG_PRESS_LO][47:32]);
      p4 = sx16_64(coef_reg[REG_PRESS_MID][15:0]);
      p5 = sx16_64(coef_reg[REG_PRESS_MID][31:16]);
      p6 = sx16_64(coef_reg[REG_PRESS_MID][47:32]);
      p7 = sx16_64(coef_reg[REG_PRESS_HI][15:0]);
      p8 = sx16_64(coef_reg[REG_PRESS_HI][31:16]);
      p9 = sx16_64(coef_reg[REG_PRESS_HI][47:32]);

      a = {12'd0, adc_t} >> 3;
      a = a - (t1 << 1);
      v1 = a * t2;
      v1 = $signed(v1) >>> 11;
      d = ({12'd0, adc_t} >> 4) - t1;
      v2 = d * d;
      v2 = $signed(v2) >>> 12;
      v2 = v2 * t3;
      v2 = $signed(v2) >>> 14;
      fine = v1 + v2;
      r.fine = fine;
      r.centi = fine * 32'd5 + RoundHalf;
      r.centi = $signed(r.centi) >>> 8;

      w1 = {{32{fine[31]}}, fine} - TempOffset;
      w2 = w1 * w1 * p6;
      w2 = w2 + ((w1 * p5) << 17);
      w2 = w2 + (p4 << 35);
      p = w1 * w1 * p3;
      p = $signed(p) >>> 8;
      w1 = p + ((w1 * p2) << 12);
      w1 = ((64'd1 << 47) + w1) * p1;
      w1 = $signed(w1) >>> 33;
      if (w1 == 64'd0) begin
        r.pascal = 32'd0;
        r.ok = 1'b0;
        return r;
      end
      p = PressBase - {44'd0, adc_p};
      p = quot_trunc(((p << 31) - w2) * PressScale, w1);
      q = $signed(p) >>> 13;
      w1 = p9 * q * q;
      w1 = $signed(w1) >>> 25;
      w2 = p8 * p;
      w2 = $signed(w2) >>> 19;
      p = p + w1 + w2;
      p = $signed(p) >>> 8;
      p = p + (p7 << 4);
      p = $signed(p) >>> 8;
      r.pascal = p[31:0];
      r.ok = 1'b1;
      return r;
    endfunction

    function void note_reading(bit [19:0] adc_p, bit [19:0] adc_t);
      pending_q.push_back(compensate(adc_p, adc_t));
    endfunction

    function void check_word(comp_word_t got);
      comp_word_t exp_w;
      n_seen++;
      if (pending_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected word: fine=%h", got.fine);
        return;
      end
      exp_w = pending_q.pop_front();
      if (!exp_w.ok) n_invalid++;
      if (exp_w != got) begin
        n_err++;
        if (n_err <= 10)
          $display("mismatch: exp fine=%h centi=%h pa=%h ok=%b got %h %h %h %b",
                   exp_w.fine, exp_w.centi, exp_w.pascal, exp_w.ok,
                   got.fine, got.centi, got.pascal, got.ok);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [19:0] pressure_raw_i = '0, temperature_raw_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [31:0] fine_temperature_o, temperature_centi_o;
  logic [31:0] pressure_pascal_o;
  logic        result_valid_o;

  comp_scoreboard sb = new();
  int idle_mode = 2;
  int hold_cycles = 0;
  int n_sent = 0;

  always #1 clk_i = ~clk_i;

  pressure_temperature_compensation_core u_top (.*);

  always @(posedge clk_i) begin
    comp_word_t w;
    if (out_valid_o && out_ready_i) begin
      w.fine = fine_temperature_o;
      w.centi = temperature_centi_o;
      w.pascal = pressure_pascal_o;
      w.ok = result_valid_o;
      sb.check_word(w);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      case (idle_mode)
        0: out_ready_i <= ($urandom_range(99) >= 86);
        1: out_ready_i <= ($urandom_range(99) >= 6);
        default: out_ready_i <= 1'b1;
      endcase
    end
  end

  task automatic reg_write(reg_idx_e idx, bit [63:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.coef_reg[idx] = v[47:0];
  endtask

  task automatic load_coefs(bit [47:0] t, bit [47:0] lo, bit [47:0] mid, bit [47:0] hi);
    reg_write(REG_TEMP, {16'hFFFF, t});
    reg_write(REG_PRESS_LO, {16'd0, lo});
    reg_write(REG_PRESS_MID, {16'd0, mid});
    reg_write(REG_PRESS_HI, {16'd0, hi});
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (90) @(posedge clk_i);
  endtask

  task automatic send_reading(bit [19:0] adc_p, bit [19:0] adc_t);
    int gap_pct;
    gap_pct = (idle_mode == 0) ? 6 : (idle_mode == 1) ? 86 : 0;
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid_i <= 1'b1;
    pressure_raw_i <= adc_p;
    temperature_raw_i <= adc_t;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_reading(adc_p, adc_t);
    n_sent++;
  endtask

  task automatic stop_sending();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_burst(int count);
    for (int i = 0; i < count; i++)
      send_reading(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)));
  endtask

  function automatic bit [47:0] rand48();
    return {16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
            16'($urandom_range(16'hFFFF))};
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset calibration: divisor is zero.
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    stop_sending();
    drain();

    // Typical sensor calibration.
    load_coefs({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
               {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    send_reading(20'h65A00, 20'h7E400);
    send_reading(20'h55555, 20'hAAAAA);
    send_reading(20'hAAAAA, 20'h55555);
    stop_sending();
    drain();

    // All calibration words at their maximum bit pattern.
    load_coefs('1, '1, '1, '1);
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h12345, 20'h80000);
    stop_sending();
    drain();

    // Signed extremes.
    load_coefs({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h8000, 16'h7FFF, 16'h0001},
               {16'h7FFF, 16'h8000, 16'h7FFF}, {16'h8000, 16'h7FFF, 16'h8000});
    send_reading(20'h00000, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'h00000);
    stop_sending();
    drain();

    // p1 zero: invalid results under random readings.
    load_coefs({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd0},
               {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
    random_burst(6);
    stop_sending();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2)
        load_coefs({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
                   {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
      else
        load_coefs(rand48(), rand48(), rand48(), rand48());
      idle_mode = ph % 3;
      if (ph == 2) hold_cycles = 400;
      random_burst(70);
      if (ph == 4) begin
        stop_sending();
        while (sb.pending_q.size() != 0) @(posedge clk_i);
      end
      random_burst(70);
      stop_sending();
      drain();
    end

    idle_mode = 2;
    drain();
    $display("Sent %0d readings over several calibration sets; %0d words checked, %0d invalid.",
             n_sent, sb.n_seen, sb.n_invalid);
    if (sb.n_err == 0 && sb.pending_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("%0d mismatches", sb.n_err);
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
